FILE: src/rled_pkg.sv
`default_nettype none

package rled_pkg;

  // Widths fixed by the word format.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned TotalW = 17;

  localparam logic [TotalW-1:0] TotalMax = 17'd131071;

  // ASCII code of the digit zero.
  localparam logic [ByteW-1:0] AsciiZero = 8'h30;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [3:0]       digit_t;

  // Control bits that travel with each queued flush command.
  typedef struct packed {
    logic stream_end;   // this command closes the sequence
    logic has_tail;     // a one-byte run follows the flushed run
    logic overflow;     // sticky overflow state for these words
  } rled_flags_t;

endpackage

`default_nettype wire

FILE: src/run_length_encoder_decimal.sv
`default_nettype none

// Run-length encoder with decimal counts. Each input word carries one byte
// and a flag for the last byte of a sequence; each run is sent as its byte,
// followed by its length in ASCII decimal digits when that length exceeds
// one, and every result word carries the running compressed length and a
// sticky overflow flag for counts saturated at COUNT_DIGITS nines. A new
// input word is taken every cycle while the two-entry command queue has
// room. A word that closes a run yields from 1 to COUNT_DIGITS + 2 result
// words, which the output sequencer sends at one word per cycle while
// out_ready_i is high, so the sustained input rate is one word per cycle
// whenever the results average no more than one per input. An input's
// first result passes through the command queue and the output register.
// After the stream end word the run and length state return to reset.
module run_length_encoder_decimal
  import rled_pkg::*;
#(
  parameter int unsigned COUNT_DIGITS = 5
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire [7:0]         in_byte_i,
  input  wire               in_last_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              burst_last_o,
  output logic              stream_end_o,
  output logic [16:0]       total_length_o,
  output logic              count_overflow_o
);

  localparam int unsigned CountW = 4 * COUNT_DIGITS;
  localparam int unsigned FlagsW = $bits(rled_flags_t);
  localparam int unsigned EntryW = CountW + 2 * ByteW + FlagsW;

  logic                          accept;
  logic                          push, pop, full, head_valid;
  byte_t                         cmd_byte, cmd_tail;
  rled_flags_t                   cmd_flags;
  logic [COUNT_DIGITS-1:0][3:0]  cmd_count;
  logic [EntryW-1:0]             push_data, head_data;
  byte_t                         head_byte, head_tail;
  rled_flags_t                   head_flags;
  logic [COUNT_DIGITS-1:0][3:0]  head_count;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  rled_front #(
    .COUNT_DIGITS(COUNT_DIGITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .push_o     (push),
    .cmd_byte_o (cmd_byte),
    .cmd_tail_o (cmd_tail),
    .cmd_flags_o(cmd_flags),
    .cmd_count_o(cmd_count)
  );

  // Commands cross the queue as one flat word.
  assign push_data = {cmd_count, cmd_tail, cmd_byte, cmd_flags};
  assign {head_count, head_tail, head_byte, head_flags} = head_data;

  rled_queue #(
    .WIDTH(EntryW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_data_o (head_data)
  );

  rled_back #(
    .COUNT_DIGITS(COUNT_DIGITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_byte_i     (head_byte),
    .head_tail_i     (head_tail),
    .head_flags_i    (head_flags),
    .head_count_i    (head_count),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .burst_last_o    (burst_last_o),
    .stream_end_o    (stream_end_o),
    .total_length_o  (total_length_o),
    .count_overflow_o(count_overflow_o)
  );

`ifndef SYNTHESIS
  // The end of a sequence is always the last word of its burst.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_end_o |-> burst_last_o)
    else $error("stream end without burst last");

  // Every result word counts itself in the running length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> total_length_o != 17'd0)
    else $error("result word with zero total length");

  // A last input word always leaves a flush command queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_last_i |=> head_valid)
    else $error("last word did not queue a flush");
`endif

endmodule

`default_nettype wire

FILE: src/rled_front.sv
`default_nettype none

module rled_front
  import rled_pkg::*;
#(
  parameter int unsigned COUNT_DIGITS = 5
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               accept_i,
  input  wire byte_t                        in_byte_i,
  input  wire                               in_last_i,
  output logic                              push_o,
  output byte_t                             cmd_byte_o,
  output byte_t                             cmd_tail_o,
  output rled_flags_t                       cmd_flags_o,
  output logic [COUNT_DIGITS-1:0][3:0]      cmd_count_o
);

  typedef logic [COUNT_DIGITS-1:0][3:0] count_t;

  byte_t  run_byte_q, run_byte_d;
  count_t count_q, count_d;
  logic   active_q, active_d;
  logic   ovf_q, ovf_d;

  logic   same;
  logic   all_nines;
  logic   carry;
  count_t count_inc;
  count_t count_one;

  assign same = active_q && (in_byte_i == run_byte_q);

  // Saturation check and ripple BCD increment of the run counter.
  always_comb begin
    all_nines = 1'b1;
    carry     = 1'b1;
    count_inc = count_q;
    count_one = '0;
    count_one[0] = 4'd1;
    for (int d = 0; d < COUNT_DIGITS; d++) begin
      if (count_q[d] != 4'd9) begin
        all_nines = 1'b0;
      end
      if (carry) begin
        if (count_q[d] == 4'd9) begin
          count_inc[d] = 4'd0;
        end else begin
          count_inc[d] = count_q[d] + 4'd1;
          carry        = 1'b0;
        end
      end
    end
  end

  // Run state update for an accepted word.
  always_comb begin
    run_byte_d = run_byte_q;
    count_d    = count_q;
    active_d   = active_q;
    ovf_d      = ovf_q;
    if (accept_i) begin
      if (same) begin
        if (all_nines) begin
          ovf_d = 1'b1;
        end else begin
          count_d = count_inc;
        end
      end else begin
        run_byte_d = in_byte_i;
        count_d    = count_one;
        active_d   = 1'b1;
      end
      if (in_last_i) begin
        run_byte_d = '0;
        count_d    = '0;
        active_d   = 1'b0;
        ovf_d      = 1'b0;
      end
    end
  end

  // Flush command for the back end.
  always_comb begin
    push_o                 = accept_i && (in_last_i || (active_q && !same));
    cmd_byte_o             = run_byte_q;
    cmd_tail_o             = in_byte_i;
    cmd_count_o            = count_q;
    cmd_flags_o.stream_end = in_last_i;
    cmd_flags_o.has_tail   = 1'b0;
    cmd_flags_o.overflow   = ovf_q;
    if (same) begin
      // Last word extends the open run, which is then flushed.
      cmd_count_o          = all_nines ? count_q : count_inc;
      cmd_flags_o.overflow = ovf_q || all_nines;
    end else if (active_q) begin
      // The byte changed: flush the old run, and the new one too on the last word.
      cmd_flags_o.has_tail = in_last_i;
    end else begin
      // No run open: a last word is a run of one on its own.
      cmd_byte_o  = in_byte_i;
      cmd_count_o = count_one;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_byte_q <= '0;
      count_q    <= '0;
      active_q   <= 1'b0;
      ovf_q      <= 1'b0;
    end else begin
      run_byte_q <= run_byte_d;
      count_q    <= count_d;
      active_q   <= active_d;
      ovf_q      <= ovf_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/rled_queue.sv
`default_nettype none

module rled_queue
  import rled_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire [WIDTH-1:0]  push_data_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic             head_valid_o,
  output logic [WIDTH-1:0] head_data_o
);

  logic [1:0][WIDTH-1:0] mem_q;
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            fill_q, fill_d;
  logic                  do_push, do_pop;

  assign full_o       = (fill_q == 2'd2);
  assign head_valid_o = (fill_q != 2'd0);
  assign head_data_o  = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Occupancy follows pushes and pops.
  always_comb begin
    fill_d = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      fill_q <= fill_d;
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/rled_back.sv
`default_nettype none

module rled_back
  import rled_pkg::*;
#(
  parameter int unsigned COUNT_DIGITS = 5
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           head_valid_i,
  input  wire byte_t                    head_byte_i,
  input  wire byte_t                    head_tail_i,
  input  wire rled_flags_t              head_flags_i,
  input  wire [COUNT_DIGITS-1:0][3:0]   head_count_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output byte_t                         out_byte_o,
  output logic                          burst_last_o,
  output logic                          stream_end_o,
  output logic [TotalW-1:0]             total_length_o,
  output logic                          count_overflow_o
);

  localparam int unsigned DigW = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;

  localparam logic [1:0] PhByte  = 2'd0;
  localparam logic [1:0] PhDigit = 2'd1;
  localparam logic [1:0] PhTail  = 2'd2;

  logic [1:0]        phase_q, phase_d;
  logic [DigW-1:0]   dig_q, dig_d;
  logic [DigW-1:0]   top;
  logic              needs_digits;
  logic              advance;
  logic              entry_done;
  byte_t             next_byte;
  logic [TotalW-1:0] total_q, total_d, total_inc;

  logic              out_valid_q;
  byte_t             out_byte_q;
  logic              burst_last_q, stream_end_q, ovf_q;
  logic [TotalW-1:0] out_total_q;

  // Highest nonzero digit of the run count.
  always_comb begin
    top = '0;
    for (int d = 0; d < COUNT_DIGITS; d++) begin
      if (head_count_i[d] != 4'd0) begin
        top = DigW'(d);
      end
    end
  end

  assign needs_digits = (top != '0) || (head_count_i[0] > 4'd1);
  assign advance      = head_valid_i && (!out_valid_q || out_ready_i);
  assign total_inc    = (total_q == TotalMax) ? total_q : total_q + 1'b1;

  // Output sequencer: run byte, count digits from the top, then the tail run.
  always_comb begin
    phase_d    = phase_q;
    dig_d      = dig_q;
    entry_done = 1'b0;
    next_byte  = head_byte_i;
    case (phase_q)
      PhByte: begin
        next_byte = head_byte_i;
        if (needs_digits) begin
          phase_d = PhDigit;
          dig_d   = top;
        end else if (head_flags_i.has_tail) begin
          phase_d = PhTail;
        end else begin
          entry_done = 1'b1;
        end
      end
      PhDigit: begin
        next_byte = AsciiZero + {4'b0000, head_count_i[dig_q]};
        if (dig_q != '0) begin
          dig_d = dig_q - 1'b1;
        end else if (head_flags_i.has_tail) begin
          phase_d = PhTail;
        end else begin
          phase_d    = PhByte;
          entry_done = 1'b1;
        end
      end
      PhTail: begin
        next_byte  = head_tail_i;
        phase_d    = PhByte;
        entry_done = 1'b1;
      end
      default: begin
        phase_d = PhByte;
      end
    endcase
  end

  assign pop_o = advance && entry_done;

  // The running length restarts after the final word of a sequence.
  always_comb begin
    total_d = total_q;
    if (advance) begin
      total_d = (entry_done && head_flags_i.stream_end) ? '0 : total_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhByte;
      dig_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      total_q <= total_d;
      if (advance) begin
        phase_q     <= phase_d;
        dig_q       <= dig_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q   <= next_byte;
      burst_last_q <= entry_done;
      stream_end_q <= entry_done && head_flags_i.stream_end;
      ovf_q        <= head_flags_i.overflow;
      out_total_q  <= total_inc;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign burst_last_o     = burst_last_q;
  assign stream_end_o     = stream_end_q;
  assign total_length_o   = out_total_q;
  assign count_overflow_o = ovf_q;

endmodule

`default_nettype wire
